>>> design/json_top_level_field_tracker_assert.svh
// Assertion macros shared by the tracker RTL.
`ifndef JSON_TOP_LEVEL_FIELD_TRACKER_ASSERT_SVH
`define JSON_TOP_LEVEL_FIELD_TRACKER_ASSERT_SVH

`ifndef ASSERT_OFF
`define JTFT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define JTFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define JTFT_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define JTFT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> design/jtft_pkg.sv
package jtft_pkg;

  localparam int NEST_BITS = 8;

  localparam int KIND_W  = 3;
  localparam int CLASS_W = 2;
  localparam int ROLE_W  = 2;
  localparam int LEVEL_W = 8;

  typedef enum logic [KIND_W-1:0] {
    EV_BEGIN     = 3'd0,
    EV_SCALAR    = 3'd1,
    EV_STRING    = 3'd2,
    EV_KEY       = 3'd3,
    EV_OBJ_START = 3'd4,
    EV_OBJ_END   = 3'd5,
    EV_ARR_START = 3'd6,
    EV_ARR_END   = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    PH_START     = 3'd0,
    PH_KEY       = 3'd1,
    PH_DONTCARE  = 3'd2,
    PH_CHALLENGE = 3'd3,
    PH_ORIGIN    = 3'd4,
    PH_NESTED    = 3'd5
  } phase_t;

  localparam logic [CLASS_W-1:0] KC_CHALLENGE = 2'd1;
  localparam logic [CLASS_W-1:0] KC_ORIGIN    = 2'd2;

  localparam logic [ROLE_W-1:0] ROLE_NONE      = 2'd0;
  localparam logic [ROLE_W-1:0] ROLE_CHALLENGE = 2'd1;
  localparam logic [ROLE_W-1:0] ROLE_ORIGIN    = 2'd2;

  typedef logic [NEST_BITS-1:0] depth_t;

endpackage

>>> design/jtft_ifs.sv
interface jtft_in_if;
  logic                          valid;
  logic                          ready;
  logic [jtft_pkg::KIND_W-1:0]   kind;
  logic [jtft_pkg::CLASS_W-1:0]  key_class;

  modport source (output valid, output kind, output key_class, input ready);
  modport sink (input valid, input kind, input key_class, output ready);
endinterface

interface jtft_out_if;
  logic                          valid;
  logic                          ready;
  logic                          accepted;
  logic [jtft_pkg::ROLE_W-1:0]   value_role;
  logic [jtft_pkg::LEVEL_W-1:0]  nest_level;
  logic                          failed;

  modport source (output valid, output accepted, output value_role, output nest_level,
                  output failed, input ready);
  modport sink (input valid, input accepted, input value_role, input nest_level,
                input failed, output ready);
endinterface

>>> design/json_top_level_field_tracker.sv
// Follows the members of one top-level JSON object from a stream of SAX-style
// events and gives one result word per event word: whether the event is legal,
// whether a string is the challenge or origin value, the depth of skipped
// containers and the sticky failure flag. An event is taken every cycle while
// the result register is empty or being drained, and its result appears in the
// result register in the cycle after acceptance; the update of phase, skip
// depth and failure flag on acceptance sets this rate of one event per clock.
`include "json_top_level_field_tracker_assert.svh"

module json_top_level_field_tracker (
  input  logic       clk,
  input  logic       rst_n,
  jtft_in_if.sink    in_ch,
  jtft_out_if.source out_ch
);

  jtft_pkg::phase_t phase_r, phase_nxt;
  jtft_pkg::depth_t skip_depth_r, skip_depth_nxt;
  logic             failed_r, failed_nxt;

  logic                           out_valid_r;
  logic                           out_accepted_r;
  logic [jtft_pkg::ROLE_W-1:0]    out_role_r;
  logic [jtft_pkg::LEVEL_W-1:0]   out_level_r;
  logic                           out_failed_r;

  jtft_pkg::kind_t               kind;
  logic                          in_fire;
  logic                          ok;
  logic [jtft_pkg::ROLE_W-1:0]   role;
  logic                          can_open;
  jtft_pkg::depth_t              depth_dec;

  assign kind         = jtft_pkg::kind_t'(in_ch.kind);
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign can_open     = (phase_r == jtft_pkg::PH_DONTCARE || phase_r == jtft_pkg::PH_NESTED)
                        && (skip_depth_r != '1);
  assign depth_dec    = (skip_depth_r != '0) ? skip_depth_r - 1'b1 : skip_depth_r;

  always_comb begin
    ok   = 1'b0;
    role = jtft_pkg::ROLE_NONE;
    if (kind == jtft_pkg::EV_BEGIN) begin
      ok = 1'b1;
    end else if (!failed_r) begin
      unique case (kind)
        jtft_pkg::EV_SCALAR: begin
          ok = (phase_r == jtft_pkg::PH_NESTED) || (phase_r == jtft_pkg::PH_DONTCARE);
        end
        jtft_pkg::EV_STRING: begin
          ok = (phase_r == jtft_pkg::PH_CHALLENGE) || (phase_r == jtft_pkg::PH_ORIGIN)
               || (phase_r == jtft_pkg::PH_DONTCARE) || (phase_r == jtft_pkg::PH_NESTED);
          if (phase_r == jtft_pkg::PH_CHALLENGE) begin
            role = jtft_pkg::ROLE_CHALLENGE;
          end else if (phase_r == jtft_pkg::PH_ORIGIN) begin
            role = jtft_pkg::ROLE_ORIGIN;
          end
        end
        jtft_pkg::EV_KEY: begin
          ok = (phase_r == jtft_pkg::PH_KEY) || (phase_r == jtft_pkg::PH_NESTED);
        end
        jtft_pkg::EV_OBJ_START: begin
          ok = (phase_r == jtft_pkg::PH_START) || can_open;
        end
        jtft_pkg::EV_OBJ_END: begin
          ok = (phase_r == jtft_pkg::PH_NESTED) || (phase_r == jtft_pkg::PH_KEY);
        end
        jtft_pkg::EV_ARR_START: begin
          ok = can_open;
        end
        jtft_pkg::EV_ARR_END: begin
          ok = (phase_r == jtft_pkg::PH_NESTED);
        end
        default: begin
          ok = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    skip_depth_nxt = skip_depth_r;
    failed_nxt     = failed_r;
    if (kind == jtft_pkg::EV_BEGIN) begin
      phase_nxt      = jtft_pkg::PH_START;
      skip_depth_nxt = '0;
      failed_nxt     = 1'b0;
    end else if (!failed_r) begin
      if (!ok) begin
        failed_nxt = 1'b1;
      end else begin
        unique case (kind)
          jtft_pkg::EV_STRING: begin
            if (phase_r != jtft_pkg::PH_NESTED) begin
              phase_nxt = jtft_pkg::PH_KEY;
            end
          end
          jtft_pkg::EV_KEY: begin
            if (phase_r == jtft_pkg::PH_KEY) begin
              if (in_ch.key_class == jtft_pkg::KC_CHALLENGE) begin
                phase_nxt = jtft_pkg::PH_CHALLENGE;
              end else if (in_ch.key_class == jtft_pkg::KC_ORIGIN) begin
                phase_nxt = jtft_pkg::PH_ORIGIN;
              end else begin
                phase_nxt = jtft_pkg::PH_DONTCARE;
              end
            end
          end
          jtft_pkg::EV_OBJ_START, jtft_pkg::EV_ARR_START: begin
            if (phase_r == jtft_pkg::PH_START) begin
              phase_nxt = jtft_pkg::PH_KEY;
            end else begin
              skip_depth_nxt = skip_depth_r + 1'b1;
              phase_nxt      = jtft_pkg::PH_NESTED;
            end
          end
          jtft_pkg::EV_OBJ_END, jtft_pkg::EV_ARR_END: begin
            if (phase_r == jtft_pkg::PH_NESTED) begin
              skip_depth_nxt = depth_dec;
              if (depth_dec == '0) begin
                phase_nxt = jtft_pkg::PH_KEY;
              end
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= jtft_pkg::PH_START;
      skip_depth_r <= '0;
      failed_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r      <= phase_nxt;
        skip_depth_r <= skip_depth_nxt;
        failed_r     <= failed_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_accepted_r <= ok;
      out_role_r     <= ok ? role : jtft_pkg::ROLE_NONE;
      out_level_r    <= jtft_pkg::LEVEL_W'(skip_depth_nxt);
      out_failed_r   <= failed_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.accepted   = out_accepted_r;
  assign out_ch.value_role = out_role_r;
  assign out_ch.nest_level = out_level_r;
  assign out_ch.failed     = out_failed_r;

  `JTFT_ASSERT_NEXT(a_failed_sticky, clk, rst_n,
    in_fire && failed_r && kind != jtft_pkg::EV_BEGIN, failed_r)
  `JTFT_ASSERT_NEXT(a_reject_fails, clk, rst_n, in_fire && !ok, failed_r && out_failed_r)
  `JTFT_ASSERT_NEXT(a_begin_clears, clk, rst_n, in_fire && kind == jtft_pkg::EV_BEGIN,
    phase_r == jtft_pkg::PH_START && skip_depth_r == '0 && !failed_r)
  `JTFT_ASSERT_IMPLY(a_depth_nested, clk, rst_n, skip_depth_r != '0,
    phase_r == jtft_pkg::PH_NESTED)
  `JTFT_ASSERT_IMPLY(a_role_accepted, clk, rst_n,
    out_valid_r && out_role_r != jtft_pkg::ROLE_NONE, out_accepted_r && !out_failed_r)

endmodule
